// ===== sv/assert_macros.svh =====
// assertion macros used by the free id pool datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define FP_ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define FP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define FP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/fp_pkg.sv =====
// package for the free id pool: defaults, codes, controller types
`timescale 1ns / 1ps

package fp_pkg;

    localparam int POOL_SLOTS_DEF = 64;
    localparam int ID_WIDTH_DEF   = 32;

    localparam int ID_FIELD_W     = 32;
    localparam int STATUS_W       = 2;
    localparam int COUNT_FIELD_W  = 7;

    localparam logic ACT_TAKE = 1'b0;
    localparam logic ACT_GIVE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_IGNORED = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        FP_IDLE,
        FP_SCAN,
        FP_DRAIN,
        FP_COMMIT
    } fp_state_t;

    // controller to datapath
    typedef struct packed {
        logic start;
        logic step;
        logic commit;
    } fp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic last_slot;
        logic rsp_free;
    } fp_sts_t;

endpackage

// ===== sv/fp_req_if.sv =====
// request channel of the free id pool
`timescale 1ns / 1ps

interface fp_req_if;

    logic                          valid;
    logic                          ready;
    logic                          action;
    logic [fp_pkg::ID_FIELD_W-1:0] id_value;

    modport source (output valid, input ready, output action, output id_value);
    modport sink   (input valid, output ready, input action, input id_value);

endinterface

// ===== sv/fp_rsp_if.sv =====
// response channel of the free id pool
`timescale 1ns / 1ps

interface fp_rsp_if;

    logic                             valid;
    logic                             ready;
    logic [fp_pkg::ID_FIELD_W-1:0]    taken_id;
    logic [fp_pkg::STATUS_W-1:0]      status;
    logic [fp_pkg::COUNT_FIELD_W-1:0] free_count;

    modport source (output valid, input ready, output taken_id, output status,
                    output free_count);
    modport sink   (input valid, output ready, input taken_id, input status,
                    input free_count);

endinterface

// ===== sv/fp_ctrl.sv =====
// controller state machine of the free id pool
`timescale 1ns / 1ps

module fp_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  fp_pkg::fp_sts_t  sts,
    output fp_pkg::fp_cmd_t  cmd
);

    fp_pkg::fp_state_t state_reg;
    fp_pkg::fp_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fp_pkg::FP_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        req_ready  = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            fp_pkg::FP_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = fp_pkg::FP_SCAN;
                end
            end
            fp_pkg::FP_SCAN:
            begin
                cmd.step = 1'b1;
                if (sts.last_slot)
                begin
                    state_next = fp_pkg::FP_DRAIN;
                end
            end
            fp_pkg::FP_DRAIN:
            begin
                // last slot read is evaluated here
                state_next = fp_pkg::FP_COMMIT;
            end
            fp_pkg::FP_COMMIT:
            begin
                if (sts.rsp_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = fp_pkg::FP_IDLE;
                end
            end
            default:
            begin
                state_next = fp_pkg::FP_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/fp_datapath.sv =====
// slot memory, occupancy bits, scan logic and response register
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fp_datapath
#(
    parameter int POOL_SLOTS = fp_pkg::POOL_SLOTS_DEF,
    parameter int ID_WIDTH   = fp_pkg::ID_WIDTH_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  fp_pkg::fp_cmd_t                  cmd,
    output fp_pkg::fp_sts_t                  sts,
    input  logic                             req_action,
    input  logic [fp_pkg::ID_FIELD_W-1:0]    req_id_value,
    output logic                             rsp_valid,
    input  logic                             rsp_ready,
    output logic [fp_pkg::ID_FIELD_W-1:0]    rsp_taken_id,
    output logic [fp_pkg::STATUS_W-1:0]      rsp_status,
    output logic [fp_pkg::COUNT_FIELD_W-1:0] rsp_free_count
);

    localparam int IDX_W = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
    localparam int CNT_W = $clog2(POOL_SLOTS + 1);

    logic [ID_WIDTH-1:0]   mem [POOL_SLOTS];
    logic [POOL_SLOTS-1:0] occ_reg;
    logic [CNT_W-1:0]      count_reg;

    // request
    logic                  action_reg;
    logic [ID_WIDTH-1:0]   id_reg;

    // scan
    logic [IDX_W-1:0]      scan_idx_reg;
    logic                  rd_pend_reg;
    logic [IDX_W-1:0]      rd_idx_reg;
    logic [ID_WIDTH-1:0]   rd_data_reg;
    logic                  rd_occ_reg;
    logic                  found_reg;
    logic                  dup_reg;
    logic [IDX_W-1:0]      hit_idx_reg;
    logic [ID_WIDTH-1:0]   hit_data_reg;

    // response
    logic                  rsp_valid_reg;
    logic [ID_WIDTH-1:0]   taken_reg;
    fp_pkg::status_t       status_reg;

    fp_pkg::status_t       status_next;
    logic [ID_WIDTH-1:0]   taken_next;
    logic                  do_clear;
    logic                  do_write;

    assign sts.last_slot = (scan_idx_reg == IDX_W'(POOL_SLOTS - 1));
    assign sts.rsp_free  = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        status_next = fp_pkg::ST_OK;
        taken_next  = '0;
        do_clear    = 1'b0;
        do_write    = 1'b0;
        if (action_reg == fp_pkg::ACT_TAKE)
        begin
            if (found_reg)
            begin
                taken_next = hit_data_reg;
                do_clear   = 1'b1;
            end
            else
            begin
                status_next = fp_pkg::ST_EMPTY;
            end
        end
        else
        begin
            priority if (id_reg == '0 || dup_reg)
            begin
                status_next = fp_pkg::ST_IGNORED;
            end
            else if (!found_reg)
            begin
                status_next = fp_pkg::ST_FULL;
            end
            else
            begin
                do_write = 1'b1;
            end
        end
    end

    // slot memory, one read per cycle during the scan, one write at commit
    always_ff @(posedge clk)
    begin
        if (cmd.commit && do_write)
        begin
            mem[hit_idx_reg] <= id_reg;
        end
        rd_data_reg <= mem[scan_idx_reg];
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= scan_idx_reg;
        if (cmd.start)
        begin
            action_reg <= req_action;
            id_reg     <= ID_WIDTH'(req_id_value);
        end
        if (rd_pend_reg && !found_reg &&
            ((action_reg == fp_pkg::ACT_TAKE) ? rd_occ_reg : !rd_occ_reg))
        begin
            hit_idx_reg  <= rd_idx_reg;
            hit_data_reg <= rd_data_reg;
        end
        if (cmd.commit)
        begin
            taken_reg  <= taken_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg       <= '0;
            count_reg     <= '0;
            scan_idx_reg  <= '0;
            rd_pend_reg   <= 1'b0;
            rd_occ_reg    <= 1'b0;
            found_reg     <= 1'b0;
            dup_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rd_pend_reg <= cmd.step;
            rd_occ_reg  <= occ_reg[scan_idx_reg];
            if (cmd.start)
            begin
                scan_idx_reg <= '0;
                found_reg    <= 1'b0;
                dup_reg      <= 1'b0;
            end
            else
            begin
                if (cmd.step)
                begin
                    scan_idx_reg <= scan_idx_reg + IDX_W'(1);
                end
                if (rd_pend_reg)
                begin
                    if ((action_reg == fp_pkg::ACT_TAKE) ? rd_occ_reg : !rd_occ_reg)
                    begin
                        found_reg <= 1'b1;
                    end
                    if (action_reg == fp_pkg::ACT_GIVE && rd_occ_reg &&
                        rd_data_reg == id_reg)
                    begin
                        dup_reg <= 1'b1;
                    end
                end
            end
            if (cmd.commit)
            begin
                rsp_valid_reg <= 1'b1;
                if (do_clear)
                begin
                    occ_reg[hit_idx_reg] <= 1'b0;
                    count_reg            <= count_reg - CNT_W'(1);
                end
                else if (do_write)
                begin
                    occ_reg[hit_idx_reg] <= 1'b1;
                    count_reg            <= count_reg + CNT_W'(1);
                end
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // count changes only at commit, which replaces the held response
    assign rsp_valid      = rsp_valid_reg;
    assign rsp_taken_id   = fp_pkg::ID_FIELD_W'(taken_reg);
    assign rsp_status     = status_reg;
    assign rsp_free_count = fp_pkg::COUNT_FIELD_W'(count_reg);

    `FP_ASSERT_ALWAYS(a_count_matches_occ, clk, rst_n, $countones(occ_reg) == count_reg, "count out of step with occupancy")
    `FP_ASSERT_IMPL(a_commit_slot_free, clk, rst_n, cmd.commit, !rsp_valid_reg || rsp_ready, "commit over an untaken response")
    `FP_ASSERT_NEXT(a_commit_shows_rsp, clk, rst_n, cmd.commit, rsp_valid_reg, "commit did not raise response valid")
    `FP_ASSERT_IMPL(a_write_target_empty, clk, rst_n, cmd.commit && do_write, !occ_reg[hit_idx_reg], "give would overwrite a held id")

endmodule

// ===== sv/free_id_pool.sv =====
// top level of the free id pool
// Free id pool: holds up to POOL_SLOTS non-zero ids of ID_WIDTH bits in a slot
// memory with one occupancy flip-flop per slot (cleared at reset, so there is
// no clearing pass). A take request returns and removes the id in the lowest
// occupied slot (status empty and id zero when nothing is held); a give request
// stores its id in the lowest empty slot unless the id is zero or already held
// (status ignored) or no slot is empty (status full). Every request produces
// exactly one response carrying the taken id, the status and the number of ids
// held afterwards. Requests are handled one at a time: each one scans every
// slot through the single read port of the slot memory, one slot per cycle,
// and passes through accept, scan, drain of the last read and commit before
// the next request is accepted. The response sits in an output register; the
// next request is accepted while it waits, and only its commit stalls until
// the response has been taken.
`timescale 1ns / 1ps

module free_id_pool
#(
    parameter int POOL_SLOTS = fp_pkg::POOL_SLOTS_DEF,
    parameter int ID_WIDTH   = fp_pkg::ID_WIDTH_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    fp_req_if.sink   req,
    fp_rsp_if.source rsp
);

    // command and status between controller and datapath
    fp_pkg::fp_cmd_t cmd;
    fp_pkg::fp_sts_t sts;

    // sequencing: idle, slot scan, drain, commit
    fp_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // slot storage, scan evaluation and response register
    fp_datapath
    #(
        .POOL_SLOTS (POOL_SLOTS),
        .ID_WIDTH   (ID_WIDTH)
    )
    u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .req_action     (req.action),
        .req_id_value   (req.id_value),
        .rsp_valid      (rsp.valid),
        .rsp_ready      (rsp.ready),
        .rsp_taken_id   (rsp.taken_id),
        .rsp_status     (rsp.status),
        .rsp_free_count (rsp.free_count)
    );

endmodule
